// ----- hw/rtl/hsfc_pkg.sv -----
// Package for the half/single float converter: request and response types,
// round mode codes and format constants. No dependencies.
`default_nettype none
package hsfc_pkg;

    typedef struct packed {
        logic        action;
        logic [31:0] operand;
    } t_req;

    typedef struct packed {
        logic [31:0] result;
        logic        overflow;
        logic        underflow;
    } t_rsp;

    // Direction codes.
    localparam logic ACT_HALF_TO_SINGLE = 1'b0;
    localparam logic ACT_SINGLE_TO_HALF = 1'b1;

    // Round mode codes; the codes above RM_DOWN behave as nearest even.
    localparam logic [2:0] RM_NEAREST_EVEN = 3'd0;
    localparam logic [2:0] RM_NEAREST_AWAY = 3'd1;
    localparam logic [2:0] RM_TOWARD_ZERO  = 3'd2;
    localparam logic [2:0] RM_UP           = 3'd3;
    localparam logic [2:0] RM_DOWN         = 3'd4;

    localparam logic [4:0]  HALF_EXP_SPECIAL = 5'h1f;
    localparam logic [7:0]  SGL_EXP_SPECIAL  = 8'hff;
    localparam logic [15:0] HALF_INF         = 16'h7c00;
    localparam logic [15:0] HALF_MAX         = 16'h7bff;
    localparam logic [15:0] HALF_QUIET       = 16'h0200;
    // Exponent bias difference, single bias minus half bias.
    localparam logic [7:0]  EXP_REBIAS       = 8'd112;

endpackage
`default_nettype wire

// ----- hw/rtl/half_single_float_converter_top.sv -----
// Top level of the half/single float converter: input register, the two
// conversion paths and the result register. Depends on hsfc_pkg,
// hsfc_widen and hsfc_narrow.
//
//   channel    signals                          direction  handshake
//   request    start, busy, i_req               in         start && !busy
//   response   o_done, o_rsp                    out        o_done, one cycle
//   config     i_cfg_valid, o_cfg_ready, data   in         valid && ready
//
// A request accepted at a clock edge passes the input register and then the
// result register; its response then shows with o_done for exactly one cycle.
// busy stays low, so a request may be accepted at every edge, one per cycle.
// The receiver cannot stall; each response is taken in the cycle it shows.
// Synchronous reset clears the valid flags and sets round mode to nearest even.
`default_nettype none
module half_single_float_converter_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire hsfc_pkg::t_req  i_req,
    output logic                 o_done,
    output hsfc_pkg::t_rsp       o_rsp,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [2:0]      i_cfg_data
);
    import hsfc_pkg::*;

    logic        r_in_vld;
    logic        n_in_vld;
    t_req        r_req;
    t_req        n_req;
    logic        r_out_vld;
    logic        n_out_vld;
    t_rsp        r_rsp;
    t_rsp        n_rsp;
    logic [2:0]  r_round_mode;
    logic [2:0]  n_round_mode;

    logic [31:0] wide_res;
    logic [15:0] narrow_res;
    logic        narrow_ovf;
    logic        narrow_unf;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    hsfc_widen u_widen (
        .i_half   (r_req.operand[15:0]),
        .o_single (wide_res)
    );

    hsfc_narrow u_narrow (
        .i_single     (r_req.operand),
        .i_round_mode (r_round_mode),
        .o_half       (narrow_res),
        .o_overflow   (narrow_ovf),
        .o_underflow  (narrow_unf)
    );

    always_comb begin
        n_in_vld     = start && !busy;
        n_req        = i_req;
        n_out_vld    = r_in_vld;
        n_round_mode = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_round_mode;
        if (r_req.action == ACT_SINGLE_TO_HALF) begin
            n_rsp.result    = {16'd0, narrow_res};
            n_rsp.overflow  = narrow_ovf;
            n_rsp.underflow = narrow_unf;
        end else begin
            n_rsp.result    = wide_res;
            n_rsp.overflow  = 1'b0;
            n_rsp.underflow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_round_mode <= RM_NEAREST_EVEN;
        end else begin
            r_in_vld     <= n_in_vld;
            r_out_vld    <= n_out_vld;
            r_round_mode <= n_round_mode;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_req <= n_req;
        end
        if (n_out_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_out_vld;
    assign o_rsp  = r_rsp;

endmodule
`default_nettype wire

// ----- hw/rtl/hsfc_widen.sv -----
// Half to single widening, purely combinational.
// Depends on hsfc_pkg for format constants.
`default_nettype none
module hsfc_widen (
    input  wire logic [15:0] i_half,
    output logic      [31:0] o_single
);
    import hsfc_pkg::*;

    logic        sign;
    logic [4:0]  exp_h;
    logic [9:0]  frac_h;
    logic [3:0]  len;
    logic [4:0]  sh_amt;
    logic [23:0] norm;

    assign sign   = i_half[15];
    assign exp_h  = i_half[14:10];
    assign frac_h = i_half[9:0];

    // Position of the leading one of a subnormal fraction.
    always_comb begin
        len = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (frac_h[i]) begin
                len = 4'(i + 1);
            end
        end
    end

    assign sh_amt = 5'd24 - {1'b0, len};
    assign norm   = {14'd0, frac_h} << sh_amt;

    always_comb begin
        priority if (exp_h == HALF_EXP_SPECIAL) begin
            o_single = {sign, SGL_EXP_SPECIAL, frac_h, 13'd0};
        end else if (exp_h != 5'd0) begin
            o_single = {sign, {3'd0, exp_h} + EXP_REBIAS, frac_h, 13'd0};
        end else if (frac_h != 10'd0) begin
            o_single = {sign, {4'd0, len} + 8'd102, norm[22:0]};
        end else begin
            o_single = {sign, 31'd0};
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/hsfc_narrow.sv -----
// Single to half narrowing with rounding, overflow and underflow flags.
// Purely combinational; depends on hsfc_pkg for round codes and constants.
`default_nettype none
module hsfc_narrow (
    input  wire logic [31:0] i_single,
    input  wire logic [2:0]  i_round_mode,
    output logic      [15:0] o_half,
    output logic             o_overflow,
    output logic             o_underflow
);
    import hsfc_pkg::*;

    logic        sign;
    logic [7:0]  exp_s;
    logic [22:0] frac_s;
    logic [2:0]  mode;
    logic [7:0]  eff;
    logic [7:0]  diff;
    logic [7:0]  he8;
    logic        huge;
    logic        normal;
    logic        tiny;
    logic [4:0]  sh;
    logic [25:0] m26;
    logic [25:0] shifted;
    logic [25:0] low_mask;
    logic [10:0] q;
    logic        guard;
    logic        sticky;
    logic        up;
    logic        to_inf;
    logic [15:0] base;
    logic [15:0] bits;

    assign sign   = i_single[31];
    assign exp_s  = i_single[30:23];
    assign frac_s = i_single[22:0];

    assign mode = (i_round_mode > RM_DOWN) ? RM_NEAREST_EVEN : i_round_mode;

    // A single subnormal is scaled like exponent one.
    assign eff    = (exp_s == 8'd0) ? 8'd1 : exp_s;
    assign diff   = 8'd126 - eff;
    assign he8    = eff - EXP_REBIAS;
    assign huge   = eff > 8'd142;
    assign normal = eff >= 8'd113;
    assign tiny   = eff < 8'd100;

    always_comb begin
        priority if (normal) begin
            sh = 5'd13;
        end else if (tiny) begin
            sh = 5'd26;
        end else begin
            sh = diff[4:0];
        end
    end

    assign m26      = {2'b00, (exp_s != 8'd0), frac_s};
    assign shifted  = m26 >> sh;
    assign low_mask = (26'd1 << (sh - 5'd1)) - 26'd1;

    // Values far below the smallest subnormal keep only a sticky bit.
    assign q      = tiny ? 11'd0 : shifted[10:0];
    assign guard  = tiny ? 1'b0 : m26[sh - 5'd1];
    assign sticky = tiny ? 1'b1 : |(m26 & low_mask);

    always_comb begin
        unique case (mode)
            RM_NEAREST_AWAY: up = guard;
            RM_TOWARD_ZERO:  up = 1'b0;
            RM_UP:           up = (guard | sticky) & ~sign;
            RM_DOWN:         up = (guard | sticky) & sign;
            default:         up = guard & (sticky | q[0]);
        endcase
    end

    assign to_inf = (mode == RM_NEAREST_EVEN) || (mode == RM_NEAREST_AWAY) ||
                    ((mode == RM_UP) && !sign) || ((mode == RM_DOWN) && sign);

    assign base = normal ? {1'b0, he8[4:0], q[9:0]} : {5'd0, q};
    assign bits = huge ? HALF_INF : (base + {15'd0, up});

    always_comb begin
        o_overflow  = 1'b0;
        o_underflow = 1'b0;
        priority if (exp_s == SGL_EXP_SPECIAL) begin
            if (frac_s != 23'd0) begin
                o_half = {sign, 15'd0} | HALF_INF | HALF_QUIET | {6'd0, frac_s[22:13]};
            end else begin
                o_half = {sign, 15'd0} | HALF_INF;
            end
        end else if (exp_s == 8'd0 && frac_s == 23'd0) begin
            o_half = {sign, 15'd0};
        end else if (bits >= HALF_INF) begin
            o_overflow = 1'b1;
            o_half     = {sign, 15'd0} | (to_inf ? HALF_INF : HALF_MAX);
        end else begin
            o_underflow = (bits == 16'd0);
            o_half      = {sign, 15'd0} | bits;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/hsfc_checker.sv -----
// Port-level checks for the half/single float converter, bound to the top.
// Depends on hsfc_pkg for the request and response types.
`default_nettype none
module hsfc_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire hsfc_pkg::t_req i_req,
    input wire logic           o_done,
    input wire hsfc_pkg::t_rsp o_rsp
);
    import hsfc_pkg::*;

    // Every accepted request yields a response after the input and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted request did not produce a response");

    // No response appears without an accepted request behind it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("response without a matching request");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_rsp.overflow && o_rsp.underflow))
        else $error("overflow and underflow both set");

    // Widening is exact and never raises a flag.
    a_widen_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_req.action, 2) == ACT_HALF_TO_SINGLE))
            |-> (!o_rsp.overflow && !o_rsp.underflow))
        else $error("flag raised on a half to single conversion");

    // A half result occupies only the low sixteen bits.
    a_narrow_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_req.action, 2) == ACT_SINGLE_TO_HALF))
            |-> (o_rsp.result[31:16] == 16'd0))
        else $error("half result has nonzero upper bits");

endmodule

bind half_single_float_converter_top hsfc_checker u_hsfc_checker (.*);
`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for half_single_float_converter_top: directed and random conversions in both
// directions under every round mode, checked against a model of the format rules kept here.
// Depends on hsfc_pkg and the converter RTL.
module tb;
    import hsfc_pkg::*;

    localparam int RAND_PER_PHASE = 155;
    localparam int CYCLE_LIMIT    = 200000;
    // Codes beyond RM_DOWN are legal register values and behave as nearest even.
    localparam logic [2:0] RM_SPARE_LO = 3'd5;
    localparam logic [2:0] RM_SPARE_HI = 3'd7;
    localparam logic [2:0] MODE_SEQ [7] = '{RM_NEAREST_AWAY, RM_TOWARD_ZERO, RM_UP, RM_DOWN,
                                            RM_SPARE_HI, RM_SPARE_LO, RM_NEAREST_EVEN};

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    t_req       req       = '0;
    logic       done;
    t_rsp       rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_data  = RM_NEAREST_EVEN;

    t_req       operand_q[$];
    t_rsp       conv_due_q[$];
    logic [2:0] mode_model = RM_NEAREST_EVEN;
    logic       req_taken  = 1'b0;
    bit         no_gaps    = 1'b0;
    int         cfg_writes = 0;
    int         failures   = 0;
    int         cycles     = 0;

    half_single_float_converter_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_done      (done),
        .o_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  f;
        logic [31:0] frac;
        int          len;
        e   = h[14:10];
        f   = h[9:0];
        len = 0;
        for (int i = 0; i < 10; i++)
            if (f[i]) len = i + 1;
        if (e == HALF_EXP_SPECIAL)
            return {h[15], SGL_EXP_SPECIAL, f, 13'd0};
        if (e != 5'd0)
            return {h[15], 8'(e) + EXP_REBIAS, f, 13'd0};
        if (f != 10'd0) begin
            // The leading one becomes the hidden bit and drops out of the fraction.
            frac = (32'(f) << (24 - len)) & 32'h007f_ffff;
            return {h[15], 8'(len + 102), frac[22:0]};
        end
        return {h[15], 31'd0};
    endfunction

    function automatic t_rsp single_to_half(input logic [31:0] x, input logic [2:0] mode_in);
        logic        s;
        logic [7:0]  e;
        logic [22:0] f;
        logic [2:0]  mode;
        logic [31:0] m, q, rem, halfw, bits;
        logic [15:0] half;
        logic        up, to_inf;
        int          ex, he, sh;
        t_rsp        r;
        s    = x[31];
        e    = x[30:23];
        f    = x[22:0];
        mode = (mode_in > RM_DOWN) ? RM_NEAREST_EVEN : mode_in;
        r    = '0;
        if (e == SGL_EXP_SPECIAL) begin
            half = (f != 23'd0) ? (HALF_INF | HALF_QUIET | {6'd0, f[22:13]}) : HALF_INF;
            r.result = {16'd0, s, half[14:0]};
            return r;
        end
        if (e == 8'd0 && f == 23'd0) begin
            r.result = {16'd0, s, 15'd0};
            return r;
        end
        m  = (e != 8'd0) ? {8'd0, 1'b1, f} : {9'd0, f};
        ex = ((e != 8'd0) ? int'(e) : 1) - 127;
        he = ex + 15;
        up = 1'b0;
        if (he > 30) begin
            bits = 32'(HALF_INF);
        end else begin
            sh = 13;
            if (he < 1) sh += 1 - he;
            if (sh > 26) begin
                // Everything is shifted out; only a sticky bit below the halfway point remains.
                q   = 32'd0;
                rem = 32'd1;
                sh  = 26;
            end else begin
                q   = m >> sh;
                rem = m & ((32'd1 << sh) - 32'd1);
            end
            halfw = 32'd1 << (sh - 1);
            case (mode)
                RM_NEAREST_AWAY: up = rem >= halfw;
                RM_TOWARD_ZERO:  up = 1'b0;
                RM_UP:           up = rem != 32'd0 && !s;
                RM_DOWN:         up = rem != 32'd0 && s;
                default:         up = rem > halfw || (rem == halfw && q[0]);
            endcase
            bits = (he >= 1) ? ((32'(he) << 10) | (q & 32'h3ff)) : q;
            bits += 32'(up);
        end
        if (bits >= 32'(HALF_INF)) begin
            to_inf = mode == RM_NEAREST_EVEN || mode == RM_NEAREST_AWAY ||
                     (mode == RM_UP && !s) || (mode == RM_DOWN && s);
            half = to_inf ? HALF_INF : HALF_MAX;
            r.overflow = 1'b1;
        end else begin
            half = bits[15:0];
            r.underflow = bits == 32'd0;
        end
        r.result = {16'd0, s, half[14:0]};
        return r;
    endfunction

    function automatic t_rsp converted(input t_req rq, input logic [2:0] mode);
        t_rsp r;
        r = '0;
        if (rq.action == ACT_HALF_TO_SINGLE)
            r.result = half_to_single(rq.operand[15:0]);
        else
            r = single_to_half(rq.operand, mode);
        return r;
    endfunction

    function automatic t_req rand_request();
        t_req        r;
        logic [31:0] v;
        int          k;
        v = $urandom();
        r.action = 1'($urandom_range(1));
        if (r.action == ACT_HALF_TO_SINGLE) begin
            case ($urandom_range(5))
                0:       v[14:10] = 5'd0;
                1:       v[14:10] = HALF_EXP_SPECIAL;
                2:       v[14:0] = 15'd0;
                default: ;
            endcase
        end else begin
            case ($urandom_range(9))
                0:       v[30:23] = SGL_EXP_SPECIAL;
                1:       v[30:23] = 8'd0;
                2:       v[30:0] = 31'd0;
                3:       v[30:13] = {8'd142, 10'h3ff};
                4:       ;
                // Exponents from deep underflow up to just past the half range.
                default: v[30:23] = 8'($urandom_range(143, 100));
            endcase
            // Clear the low bits, often leaving an exact halfway point for rounding.
            if ($urandom_range(2) != 0) begin
                k = $urandom_range(23, 1);
                v = v & ~((32'd1 << k) - 32'd1);
                if ($urandom_range(1) != 0) v[k - 1] = 1'b1;
            end
        end
        r.operand = v;
        return r;
    endfunction

    task automatic queue_op(input logic act, input logic [31:0] operand);
        t_req r;
        r.action  = act;
        r.operand = operand;
        operand_q.push_back(r);
    endtask

    task automatic drain();
        while (operand_q.size() != 0 || start || conv_due_q.size() != 0) @(negedge clk);
        // Let the last response leave the pipeline; leave some margin before touching the register.
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(input logic [2:0] m);
        int seen;
        seen = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        while (cfg_writes == seen) @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Request driver: a request stays on the port until the block takes it.
    always @(negedge clk) begin
        if (rst_n && !(start && !req_taken)) begin
            if (operand_q.size() != 0 && (no_gaps || $urandom_range(99) >= 26)) begin
                start <= 1'b1;
                req   <= operand_q.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Response monitor, request capture and round mode tracking.
    always @(posedge clk) begin
        t_rsp want;
        req_taken <= rst_n && start && !busy;
        if (rst_n && done) begin
            if (conv_due_q.size() == 0) begin
                $error("result: expected none, actual %h", rsp.result);
                failures++;
            end else begin
                want = conv_due_q.pop_front();
                if (rsp.result !== want.result) begin
                    $error("result: expected %h, actual %h", want.result, rsp.result);
                    failures++;
                end
                if (rsp.overflow !== want.overflow) begin
                    $error("overflow: expected %b, actual %b", want.overflow, rsp.overflow);
                    failures++;
                end
                if (rsp.underflow !== want.underflow) begin
                    $error("underflow: expected %b, actual %b", want.underflow, rsp.underflow);
                    failures++;
                end
            end
        end
        if (rst_n && start && !busy)
            conv_due_q.push_back(converted(req, mode_model));
        if (rst_n && cfg_valid && cfg_ready) begin
            mode_model <= cfg_data;
            cfg_writes++;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Half operands: zeros, infinities, a NaN, subnormal and normal limits, junk upper bits.
        queue_op(ACT_HALF_TO_SINGLE, 32'h0000_0000);
        queue_op(ACT_HALF_TO_SINGLE, 32'h0000_8000);
        queue_op(ACT_HALF_TO_SINGLE, 32'h0000_7c00);
        queue_op(ACT_HALF_TO_SINGLE, 32'h0000_fc00);
        queue_op(ACT_HALF_TO_SINGLE, 32'h0000_7e01);
        queue_op(ACT_HALF_TO_SINGLE, 32'h0000_0001);
        queue_op(ACT_HALF_TO_SINGLE, 32'h0000_03ff);
        queue_op(ACT_HALF_TO_SINGLE, 32'h0000_0400);
        queue_op(ACT_HALF_TO_SINGLE, 32'h0000_fbff);
        queue_op(ACT_HALF_TO_SINGLE, 32'hdead_3c00);
        // Single operands: specials, a NaN whose payload sits below the kept bits,
        // overflow edges, underflow edges and halfway ties at 1.0.
        queue_op(ACT_SINGLE_TO_HALF, 32'h0000_0000);
        queue_op(ACT_SINGLE_TO_HALF, 32'h8000_0000);
        queue_op(ACT_SINGLE_TO_HALF, 32'h7f80_0000);
        queue_op(ACT_SINGLE_TO_HALF, 32'hff80_0000);
        queue_op(ACT_SINGLE_TO_HALF, 32'h7f80_0001);
        queue_op(ACT_SINGLE_TO_HALF, 32'hffc0_0000);
        queue_op(ACT_SINGLE_TO_HALF, 32'h477f_e000);
        queue_op(ACT_SINGLE_TO_HALF, 32'h477f_f000);
        queue_op(ACT_SINGLE_TO_HALF, 32'hc780_0000);
        queue_op(ACT_SINGLE_TO_HALF, 32'h7f7f_ffff);
        queue_op(ACT_SINGLE_TO_HALF, 32'h3300_0000);
        queue_op(ACT_SINGLE_TO_HALF, 32'h3300_0001);
        queue_op(ACT_SINGLE_TO_HALF, 32'h0000_0001);
        queue_op(ACT_SINGLE_TO_HALF, 32'h3f80_1000);
        queue_op(ACT_SINGLE_TO_HALF, 32'h3f80_3000);
        repeat (RAND_PER_PHASE) operand_q.push_back(rand_request());
        drain();

        for (int p = 0; p < 7; p++) begin
            write_mode(MODE_SEQ[p]);
            // One phase runs back to back with no gaps on the request side.
            no_gaps = (MODE_SEQ[p] == RM_UP);
            repeat (RAND_PER_PHASE) operand_q.push_back(rand_request());
            drain();
            no_gaps = 1'b0;
        end

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
